// ----- sv/depthwise_conv7x7_s2_mult2_top_assert.svh -----
// Assertion macros for the depthwise conv RTL.
// No dependencies; included by dwc_dp, which checks its own logic.
`ifndef DEPTHWISE_CONV7X7_S2_MULT2_TOP_ASSERT_SVH
`define DEPTHWISE_CONV7X7_S2_MULT2_TOP_ASSERT_SVH

// same-cycle implication
`define DWC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DWC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/dwc_pkg.sv -----
// Shared types, codes and fp32 arithmetic for the depthwise 7x7 conv block.
// No dependencies.
package dwc_pkg;

	localparam int KSIZE = 7;
	localparam int NTAPS = KSIZE * KSIZE;

	localparam logic [1:0] OP_WEIGHT = 2'd0;
	localparam logic [1:0] OP_PIXEL  = 2'd1;
	localparam logic [1:0] OP_PRIOR  = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [2:0] CFG_IN_ROWS  = 3'd0;
	localparam logic [2:0] CFG_IN_COLS  = 3'd1;
	localparam logic [2:0] CFG_OUT_ROWS = 3'd2;
	localparam logic [2:0] CFG_OUT_COLS = 3'd3;
	localparam logic [2:0] CFG_BETA     = 3'd4;

	typedef struct packed {
		logic win_start;
		logic tap_rd;
		logic tap_mul;
		logic tap_add;
		logic tap_next;
		logic pri_rd;
		logic pri_mul;
		logic pri_add;
		logic emit;
	} dwc_cmd_t;

	typedef struct packed {
		logic tap_ok;
		logic tap_end;
		logic no_hits;
		logic pair_end;
		logic beta_nz;
		logic out_busy;
	} dwc_stat_t;

	typedef struct packed {
		logic [1:0] cnt;
		logic [7:0] o0;
		logic [7:0] o1;
	} dwc_hits_t;

	// Output indices along one axis completed by position p (size n, m outputs).
	function automatic dwc_hits_t axis_hits(input logic [8:0] p, input logic [8:0] n,
		input logic [7:0] m);
		dwc_hits_t h;
		logic [8:0] lo;
		logic [8:0] o;
		h = '0;
		lo = (n >= 9'd4) ? ((n - 9'd3) >> 1) : 9'd0;
		o = (p - 9'd3) >> 1;
		if (p + 9'd1 == n) begin
			if (lo < {1'b0, m}) begin
				h.o0 = lo[7:0];
				h.cnt = 2'd1;
				if (lo + 9'd1 < {1'b0, m}) begin
					h.o1 = 8'(lo + 9'd1);
					h.cnt = 2'd2;
				end
			end
		end else if (p >= 9'd3 && p[0]) begin
			if (o < {1'b0, m}) begin
				h.o0 = o[7:0];
				h.cnt = 2'd1;
			end
		end
		return h;
	endfunction

	// v mod 7 for v < 512 via reciprocal multiply and one correction.
	function automatic logic [2:0] mod7(input logic [8:0] v);
		logic [16:0] p;
		logic [8:0] r;
		p = 17'(v) * 17'd73;
		r = v - 9'(p[16:9]) * 9'd7;
		if (r >= 9'd7) r = r - 9'd7;
		return r[2:0];
	endfunction

	// IEEE single multiply, round to nearest even, subnormals kept.
	function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
		logic sr, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, g, st, st0;
		logic [7:0] ea, eb, ef;
		logic [23:0] ma, mb, mant;
		logic [47:0] p;
		logic [5:0] lpos;
		logic signed [10:0] bexp, rsh;
		logic [97:0] sh;
		logic [30:0] mag;
		logic [31:0] r;
		sr = a[31] ^ b[31];
		a_nan = (&a[30:23]) && (|a[22:0]);
		b_nan = (&b[30:23]) && (|b[22:0]);
		a_inf = (&a[30:23]) && !(|a[22:0]);
		b_inf = (&b[30:23]) && !(|b[22:0]);
		a_zero = (a[30:0] == 31'd0);
		b_zero = (b[30:0] == 31'd0);
		ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
		eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
		ma = {|a[30:23], a[22:0]};
		mb = {|b[30:23], b[22:0]};
		r = '0;
		if (a_nan) begin
			r = a | 32'h0040_0000;
		end else if (b_nan) begin
			r = b | 32'h0040_0000;
		end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
			r = 32'hFFC0_0000;
		end else if (a_inf || b_inf) begin
			r = {sr, 8'hFF, 23'd0};
		end else if (a_zero || b_zero) begin
			r = {sr, 31'd0};
		end else begin
			p = 48'(ma) * 48'(mb);
			lpos = '0;
			for (int i = 0; i < 48; i++) begin
				if (p[i]) lpos = 6'(i);
			end
			bexp = 11'(lpos) + 11'(ea) + 11'(eb) - 11'sd173;
			if (bexp >= 1) rsh = 11'(lpos) - 11'sd23;
			else rsh = 11'sd151 - 11'(ea) - 11'(eb);
			sh = {p, 50'd0};
			st0 = 1'b0;
			if (rsh < 0) begin
				sh = sh << 7'(-rsh);
			end else if (rsh > 97) begin
				st0 = |sh;
				sh = '0;
			end else begin
				st0 = |(sh & ~({98{1'b1}} << 7'(rsh)));
				sh = sh >> 7'(rsh);
			end
			mant = sh[73:50];
			g = sh[49];
			st = (|sh[48:0]) | st0;
			if (bexp > 254) begin
				r = {sr, 8'hFF, 23'd0};
			end else begin
				ef = (bexp >= 1) ? bexp[7:0] : 8'd0;
				mag = {ef, mant[22:0]} + 31'(g & (st | mant[0]));
				r = {sr, mag};
			end
		end
		return r;
	endfunction

	// IEEE single add, round to nearest even, subnormals kept.
	function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
		logic a_nan, b_nan, a_inf, b_inf, sub, g, st;
		logic [31:0] x, y, r;
		logic [7:0] ex, ey, d, ef;
		logic [23:0] mx, my, mant;
		logic [26:0] aligned, s27;
		logic [27:0] bigv, sum;
		logic [4:0] lpos;
		logic [8:0] shn, ex9, exp9;
		logic [30:0] mag;
		a_nan = (&a[30:23]) && (|a[22:0]);
		b_nan = (&b[30:23]) && (|b[22:0]);
		a_inf = (&a[30:23]) && !(|a[22:0]);
		b_inf = (&b[30:23]) && !(|b[22:0]);
		r = '0;
		if (a_nan) begin
			r = a | 32'h0040_0000;
		end else if (b_nan) begin
			r = b | 32'h0040_0000;
		end else if (a_inf && b_inf && (a[31] != b[31])) begin
			r = 32'hFFC0_0000;
		end else if (a_inf) begin
			r = a;
		end else if (b_inf) begin
			r = b;
		end else if (a[30:0] == 31'd0 && b[30:0] == 31'd0) begin
			r = {a[31] & b[31], 31'd0};
		end else begin
			if (a[30:0] >= b[30:0]) begin
				x = a;
				y = b;
			end else begin
				x = b;
				y = a;
			end
			ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
			ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
			mx = {|x[30:23], x[22:0]};
			my = {|y[30:23], y[22:0]};
			d = ex - ey;
			sub = x[31] ^ y[31];
			bigv = {1'b0, mx, 3'd0};
			aligned = {my, 3'd0};
			if (d >= 8'd27) begin
				aligned = {26'd0, |my};
			end else begin
				aligned = (aligned >> d) | 27'(|(aligned & ~({27{1'b1}} << d)));
			end
			sum = sub ? (bigv - {1'b0, aligned}) : (bigv + {1'b0, aligned});
			ex9 = {1'b0, ex};
			if (sum == 28'd0) begin
				r = 32'd0;
			end else begin
				if (sum[27]) begin
					s27 = sum[27:1] | 27'(sum[0]);
					exp9 = ex9 + 9'd1;
				end else begin
					lpos = '0;
					for (int i = 0; i < 27; i++) begin
						if (sum[i]) lpos = 5'(i);
					end
					shn = 9'd26 - 9'(lpos);
					if (shn > ex9 - 9'd1) shn = ex9 - 9'd1;
					s27 = sum[26:0] << shn;
					exp9 = ex9 - shn;
				end
				mant = s27[26:3];
				g = s27[2];
				st = |s27[1:0];
				if (exp9 >= 9'd255) begin
					r = {x[31], 8'hFF, 23'd0};
				end else begin
					ef = mant[23] ? exp9[7:0] : 8'd0;
					mag = {ef, mant[22:0]} + 31'(g & (st | mant[0]));
					r = {x[31], mag};
				end
			end
		end
		return r;
	endfunction

endpackage

// ----- sv/dwc_ctrl.sv -----
// Sequencing state machine of the depthwise conv block.
// Depends on dwc_pkg (command and status structs, opcodes).
module dwc_ctrl
	import dwc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_acc,
	input  logic [1:0] in_op,
	input  dwc_stat_t  stat,
	output logic       in_ready,
	output dwc_cmd_t   cmd
);

	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_PIX   = 11'b000_0000_0010,
		S_WIN   = 11'b000_0000_0100,
		S_TCHK  = 11'b000_0000_1000,
		S_TMUL  = 11'b000_0001_0000,
		S_TADD  = 11'b000_0010_0000,
		S_POST  = 11'b000_0100_0000,
		S_PRD   = 11'b000_1000_0000,
		S_PMUL  = 11'b001_0000_0000,
		S_PADD  = 11'b010_0000_0000,
		S_EMIT  = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_acc && in_op == OP_PIXEL) state_d = S_PIX;
			end
			S_PIX: begin
				state_d = stat.no_hits ? S_IDLE : S_WIN;
			end
			S_WIN: begin
				cmd.win_start = 1'b1;
				state_d = S_TCHK;
			end
			S_TCHK: begin
				if (stat.tap_ok) begin
					cmd.tap_rd = 1'b1;
					state_d = S_TMUL;
				end else begin
					cmd.tap_next = 1'b1;
					state_d = stat.tap_end ? S_POST : S_TCHK;
				end
			end
			S_TMUL: begin
				cmd.tap_mul = 1'b1;
				state_d = S_TADD;
			end
			S_TADD: begin
				cmd.tap_add = 1'b1;
				cmd.tap_next = 1'b1;
				state_d = stat.tap_end ? S_POST : S_TCHK;
			end
			S_POST: begin
				state_d = stat.beta_nz ? S_PRD : S_EMIT;
			end
			S_PRD: begin
				cmd.pri_rd = 1'b1;
				state_d = S_PMUL;
			end
			S_PMUL: begin
				cmd.pri_mul = 1'b1;
				state_d = S_PADD;
			end
			S_PADD: begin
				cmd.pri_add = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (!stat.out_busy) begin
					cmd.emit = 1'b1;
					state_d = stat.pair_end ? S_IDLE : S_WIN;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- sv/dwc_dp.sv -----
// Datapath of the depthwise conv block: config, filter/line/prior stores,
// window walk, two fp32 multiply-add lanes and the result register.
// Depends on dwc_pkg and the assertion macro header.
`include "depthwise_conv7x7_s2_mult2_top_assert.svh"
module dwc_dp
	import dwc_pkg::*;
#(
	parameter int MAX_WIDTH   = 256,
	parameter int MAX_HEIGHT  = 256,
	parameter int PRIOR_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_acc,
	input  logic [1:0]  in_op,
	input  logic [6:0]  in_tap,
	input  logic [31:0] in_value,
	input  logic [31:0] in_pf,
	input  logic [31:0] in_ps,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	input  dwc_cmd_t    cmd,
	output dwc_stat_t   stat,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] out_first,
	output logic [31:0] out_second,
	output logic [6:0]  out_row,
	output logic [6:0]  out_col,
	output logic        out_last,
	output logic        out_missing
);

	localparam int LS_DEPTH = KSIZE * MAX_WIDTH;
	localparam int LS_AW    = $clog2(LS_DEPTH);
	localparam int PW       = (PRIOR_DEPTH > 1) ? $clog2(PRIOR_DEPTH) : 1;
	localparam int CNT_W    = $clog2(PRIOR_DEPTH + 1);

	// configuration
	logic [8:0]  in_rows_q, in_cols_q;
	logic [7:0]  out_rows_q, out_cols_q;
	logic [31:0] beta_q;

	// derived geometry
	logic [8:0] rows, cols, orows9, ocols9;
	logic [7:0] orows, ocols;

	always_comb begin
		if (in_rows_q == 9'd0) rows = 9'd1;
		else if (32'(in_rows_q) > 32'(MAX_HEIGHT)) rows = 9'(MAX_HEIGHT);
		else rows = in_rows_q;
		if (in_cols_q == 9'd0) cols = 9'd1;
		else if (32'(in_cols_q) > 32'(MAX_WIDTH)) cols = 9'(MAX_WIDTH);
		else cols = in_cols_q;
		orows9 = ((rows - 9'd1) >> 1) + 9'd1;
		ocols9 = ((cols - 9'd1) >> 1) + 9'd1;
		orows = ({1'b0, out_rows_q} < orows9) ? out_rows_q : orows9[7:0];
		ocols = ({1'b0, out_cols_q} < ocols9) ? out_cols_q : ocols9[7:0];
	end

	// pixel position
	logic [8:0] pix_row_q, pix_col_q, eff_row, eff_col;
	logic [2:0] rmod_q, eff_mod;
	logic       wrap, pix_acc;

	assign pix_acc = in_acc && (in_op == OP_PIXEL);
	assign wrap    = (pix_row_q >= rows) || (pix_col_q >= cols);
	assign eff_row = wrap ? 9'd0 : pix_row_q;
	assign eff_col = wrap ? 9'd0 : pix_col_q;
	assign eff_mod = wrap ? 3'd0 : rmod_q;

	dwc_hits_t rh, ch;
	assign rh = axis_hits(eff_row, rows, orows);
	assign ch = axis_hits(eff_col, cols, ocols);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_rows_q  <= 9'd1;
			in_cols_q  <= 9'd1;
			out_rows_q <= 8'd1;
			out_cols_q <= 8'd1;
			beta_q     <= '0;
			pix_row_q  <= '0;
			pix_col_q  <= '0;
			rmod_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_IN_ROWS: begin
						in_rows_q <= cfg_wdata[8:0];
						pix_row_q <= '0;
						pix_col_q <= '0;
						rmod_q    <= '0;
					end
					CFG_IN_COLS: begin
						in_cols_q <= cfg_wdata[8:0];
						pix_row_q <= '0;
						pix_col_q <= '0;
						rmod_q    <= '0;
					end
					CFG_OUT_ROWS: out_rows_q <= cfg_wdata[7:0];
					CFG_OUT_COLS: out_cols_q <= cfg_wdata[7:0];
					CFG_BETA:     beta_q <= cfg_wdata;
					default: ;
				endcase
			end else if (pix_acc) begin
				if (eff_col + 9'd1 >= cols) begin
					pix_col_q <= '0;
					if (eff_row + 9'd1 >= rows) begin
						pix_row_q <= '0;
						rmod_q    <= '0;
					end else begin
						pix_row_q <= eff_row + 9'd1;
						rmod_q    <= (eff_mod == 3'(KSIZE - 1)) ? 3'd0 : eff_mod + 3'd1;
					end
				end else begin
					pix_row_q <= eff_row;
					pix_col_q <= eff_col + 9'd1;
					rmod_q    <= eff_mod;
				end
			end
		end
	end

	// hit lists of the current pixel and pair walk
	logic [1:0] nr_q, nc_q;
	logic [7:0] rl0_q, rl1_q, cl0_q, cl1_q;
	logic       i_q, j_q;
	logic [7:0] cur_orow, cur_ocol;

	assign cur_orow = i_q ? rl1_q : rl0_q;
	assign cur_ocol = j_q ? cl1_q : cl0_q;

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			nr_q  <= rh.cnt;
			nc_q  <= ch.cnt;
			rl0_q <= rh.o0;
			rl1_q <= rh.o1;
			cl0_q <= ch.o0;
			cl1_q <= ch.o1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= 1'b0;
			j_q <= 1'b0;
		end else if (pix_acc) begin
			i_q <= 1'b0;
			j_q <= 1'b0;
		end else if (cmd.emit) begin
			if ({1'b0, j_q} == nc_q - 2'd1) begin
				j_q <= 1'b0;
				i_q <= 1'b1;
			end else begin
				j_q <= 1'b1;
			end
		end
	end

	// window walk
	logic signed [10:0] y_q, x_q, xbase;
	logic [2:0]  tx_q, ymod_q;
	logic [5:0]  tidx_q;

	assign xbase = $signed({2'b00, cur_ocol, 1'b0}) - 11'sd3;

	always_ff @(posedge clk) begin
		if (cmd.win_start) begin
			y_q    <= $signed({2'b00, cur_orow, 1'b0}) - 11'sd3;
			x_q    <= xbase;
			tx_q   <= '0;
			tidx_q <= '0;
			ymod_q <= mod7({cur_orow, 1'b0} + 9'd4);
		end else if (cmd.tap_next && !stat.tap_end) begin
			tidx_q <= tidx_q + 6'd1;
			if (tx_q == 3'(KSIZE - 1)) begin
				tx_q   <= '0;
				x_q    <= xbase;
				y_q    <= y_q + 11'sd1;
				ymod_q <= (ymod_q == 3'(KSIZE - 1)) ? 3'd0 : ymod_q + 3'd1;
			end else begin
				tx_q <= tx_q + 3'd1;
				x_q  <= x_q + 11'sd1;
			end
		end
	end

	// filter store, split per output channel
	logic [31:0] filt_a [NTAPS];
	logic [31:0] filt_b [NTAPS];
	logic [31:0] fa_rd_q, fb_rd_q;

	always_ff @(posedge clk) begin
		if (in_acc && in_op == OP_WEIGHT) begin
			if (in_tap < 7'(NTAPS)) filt_a[6'(in_tap)] <= in_value;
			else if (in_tap < 7'(2 * NTAPS)) filt_b[6'(in_tap - 7'(NTAPS))] <= in_value;
		end
		if (cmd.tap_rd) begin
			fa_rd_q <= filt_a[tidx_q];
			fb_rd_q <= filt_b[tidx_q];
		end
	end

	// line store: KSIZE rows of MAX_WIDTH pixels
	logic [31:0] ls_mem [LS_DEPTH];
	logic [31:0] ls_rd_q;
	logic [LS_AW-1:0] ls_waddr, ls_raddr;

	assign ls_waddr = LS_AW'(eff_mod) * LS_AW'(MAX_WIDTH) + LS_AW'(eff_col);
	assign ls_raddr = LS_AW'(ymod_q) * LS_AW'(MAX_WIDTH) + LS_AW'(x_q[8:0]);

	always_ff @(posedge clk) begin
		if (pix_acc) ls_mem[ls_waddr] <= in_value;
		if (cmd.tap_rd) ls_rd_q <= ls_mem[ls_raddr];
	end

	// prior pair queue
	logic [63:0] pq_mem [PRIOR_DEPTH];
	logic [63:0] pq_rd_q;
	logic [PW-1:0] head_q, tail_q;
	logic [CNT_W-1:0] pri_cnt_q;
	logic push, pop, missing_q;

	assign push = in_acc && (in_op == OP_PRIOR) && (pri_cnt_q < CNT_W'(PRIOR_DEPTH));
	assign pop  = cmd.pri_rd && (pri_cnt_q != '0);

	always_ff @(posedge clk) begin
		if (push) pq_mem[tail_q] <= {in_ps, in_pf};
		if (cmd.pri_rd) pq_rd_q <= pq_mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			pri_cnt_q <= '0;
			missing_q <= 1'b0;
		end else begin
			if (push) tail_q <= (tail_q == PW'(PRIOR_DEPTH - 1)) ? '0 : tail_q + PW'(1);
			if (pop) head_q <= (head_q == PW'(PRIOR_DEPTH - 1)) ? '0 : head_q + PW'(1);
			if (push) pri_cnt_q <= pri_cnt_q + CNT_W'(1);
			else if (pop) pri_cnt_q <= pri_cnt_q - CNT_W'(1);
			if (cmd.win_start) missing_q <= 1'b0;
			else if (cmd.pri_rd) missing_q <= (pri_cnt_q == '0);
		end
	end

	// two multiply-add lanes, shared between taps and the prior term
	logic [31:0] mul_a_x, mul_a_y, mul_b_x, mul_b_y;
	logic [31:0] prod_a_q, prod_b_q, acc_a_q, acc_b_q;

	always_comb begin
		if (cmd.pri_mul) begin
			mul_a_x = missing_q ? 32'd0 : pq_rd_q[31:0];
			mul_b_x = missing_q ? 32'd0 : pq_rd_q[63:32];
			mul_a_y = beta_q;
			mul_b_y = beta_q;
		end else begin
			mul_a_x = ls_rd_q;
			mul_b_x = ls_rd_q;
			mul_a_y = fa_rd_q;
			mul_b_y = fb_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tap_mul || cmd.pri_mul) begin
			prod_a_q <= fp_mul(mul_a_x, mul_a_y);
			prod_b_q <= fp_mul(mul_b_x, mul_b_y);
		end
		if (cmd.win_start) begin
			acc_a_q <= '0;
			acc_b_q <= '0;
		end else if (cmd.tap_add || cmd.pri_add) begin
			acc_a_q <= fp_add(acc_a_q, prod_a_q);
			acc_b_q <= fp_add(acc_b_q, prod_b_q);
		end
	end

	// result register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_first   <= acc_a_q;
			out_second  <= acc_b_q;
			out_row     <= cur_orow[6:0];
			out_col     <= cur_ocol[6:0];
			out_last    <= stat.pair_end;
			out_missing <= stat.beta_nz && missing_q;
		end
	end

	assign out_valid = out_valid_q;

	// status
	assign stat.tap_ok   = (y_q >= 0) && (y_q < $signed({2'b00, rows}))
		&& (x_q >= 0) && (x_q < $signed({2'b00, cols}));
	assign stat.tap_end  = (tidx_q == 6'(NTAPS - 1));
	assign stat.no_hits  = (nr_q == 2'd0) || (nc_q == 2'd0);
	assign stat.pair_end = ({1'b0, i_q} == nr_q - 2'd1) && ({1'b0, j_q} == nc_q - 2'd1);
	assign stat.beta_nz  = (beta_q[30:0] != 31'd0);
	assign stat.out_busy = out_valid_q && !out_ready;

	`DWC_ASSERT_IMP(a_fifo_bound, clk, arst_n, 1'b1, pri_cnt_q <= CNT_W'(PRIOR_DEPTH), "prior queue over depth")
	`DWC_ASSERT_IMP(a_emit_pair, clk, arst_n, cmd.emit, ({1'b0, i_q} < nr_q) && ({1'b0, j_q} < nc_q), "emit outside hit list")
	`DWC_ASSERT_NXT(a_emit_loads, clk, arst_n, cmd.emit, out_valid_q, "result register not loaded")
	`DWC_ASSERT_IMP(a_tap_read_in_image, clk, arst_n, cmd.tap_rd, stat.tap_ok && (tidx_q <= 6'(NTAPS - 1)), "tap read outside image")

endmodule

// ----- sv/depthwise_conv7x7_s2_mult2_top.sv -----
// Depthwise 7x7 / stride 2 / pad 3 fp32 convolution, two output channels.
// Inputs arrive on the s_ stream, results leave on the m_ stream; config on cfg_.
// s_tuser = opcode: load weight (tap in tdata[6:0], value in tdata[38:7]),
//   pixel (value in tdata[38:7], raster order), or prior pair (tdata[102:39]).
// Weight and prior items are stored while idle. A pixel is written to the 7-row line
//   store and then produces zero to four result pairs in row-major order.
// Each pair walks the 49 window taps on a shared pair of fp32 multiply/add
//   lanes: a tap inside the image is checked, read, multiplied and added, a
//   clipped tap is only checked; setup, post and emit steps follow, plus a
//   prior pop, multiply and add when beta is nonzero.
// s_tready is high only while no pixel is in work; one item is in flight.
// Results sit in an output register; the next pair is computed while one
//   waits, and the block stalls in the emit step if m_tready stays low.
// Reset clears geometry to 1x1, beta to zero, the position and the prior
//   queue. Filter and line stores are not cleared and must be written first.
// cfg_we writes register cfg_index at once: 0 in_rows, 1 in_cols (both
//   restart the frame), 2 out_rows, 3 out_cols, 4 beta bits.
module depthwise_conv7x7_s2_mult2_top
	import dwc_pkg::*;
#(
	parameter int MAX_WIDTH   = 256,
	parameter int MAX_HEIGHT  = 256,
	parameter int PRIOR_DEPTH = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [103:0] s_tdata,   // tap_index, value_bits, prior_first, prior_second, pad
	input  logic [1:0]   s_tuser,   // opcode
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [79:0]  m_tdata,   // first_value, second_value, out_row, out_col, pad
	output logic         m_tuser,   // prior_missing
	output logic         m_tlast,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_wdata
);

	logic        in_acc;
	dwc_cmd_t    cmd;
	dwc_stat_t   stat;
	logic [31:0] res_first, res_second;
	logic [6:0]  res_row, res_col;

	// an item is taken on the valid/ready edge
	assign in_acc = s_tvalid && s_tready;

	dwc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_acc   (in_acc),
		.in_op    (s_tuser),
		.stat     (stat),
		.in_ready (s_tready),
		.cmd      (cmd)
	);

	dwc_dp #(
		.MAX_WIDTH   (MAX_WIDTH),
		.MAX_HEIGHT  (MAX_HEIGHT),
		.PRIOR_DEPTH (PRIOR_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_acc      (in_acc),
		.in_op       (s_tuser),
		.in_tap      (s_tdata[6:0]),
		.in_value    (s_tdata[38:7]),
		.in_pf       (s_tdata[70:39]),
		.in_ps       (s_tdata[102:71]),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_first   (res_first),
		.out_second  (res_second),
		.out_row     (res_row),
		.out_col     (res_col),
		.out_last    (m_tlast),
		.out_missing (m_tuser)
	);

	// pack result fields, lowest field first, zero pad to whole bytes
	assign m_tdata = {2'b00, res_col, res_row, res_second, res_first};

endmodule
